@@ rtl/core/srs_pkg.sv @@
package srs_pkg;

  typedef enum logic [1:0] {
    CMD_BASE   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QWRITE,
    ST_DIV,
    ST_HREAD,
    ST_HWRITE,
    ST_WREAD,
    ST_WMUL,
    ST_WADD,
    ST_WPCT,
    ST_REPORT,
    ST_TREAD,
    ST_TOUT
  } state_t;

  localparam logic [2:0] SEL_LENGTH = 3'd0;
  localparam logic [2:0] SEL_GC     = 3'd1;
  localparam logic [2:0] SEL_QUAL   = 3'd2;
  localparam logic [2:0] SEL_MEANQ  = 3'd3;
  localparam logic [2:0] SEL_NXX    = 3'd4;

  localparam logic [3:0] KIND_READS    = 4'd0;
  localparam logic [3:0] KIND_BASES    = 4'd1;
  localparam logic [3:0] KIND_LONGEST  = 4'd2;
  localparam logic [3:0] KIND_MEDIAN   = 4'd3;
  localparam logic [3:0] KIND_N50      = 4'd4;
  localparam logic [3:0] KIND_N95      = 4'd5;
  localparam logic [3:0] KIND_N05      = 4'd6;
  localparam logic [3:0] KIND_A        = 4'd7;
  localparam logic [3:0] KIND_C        = 4'd8;
  localparam logic [3:0] KIND_G        = 4'd9;
  localparam logic [3:0] KIND_TU       = 4'd10;
  localparam logic [3:0] KIND_OFFSET   = 4'd11;
  localparam logic [3:0] KIND_OTHER    = 4'd12;
  localparam logic [3:0] KIND_OVERFLOW = 4'd13;
  localparam logic [3:0] KIND_TABLE    = 4'd14;

  localparam int GC_BINS   = 101;
  localparam int QUAL_BINS = 256;
  localparam int NXX_BINS  = 101;

  localparam logic [6:0] GC_MAX    = 7'd100;
  localparam logic [6:0] PCT_MAX   = 7'd100;
  localparam logic [6:0] PCT_N50   = 7'd50;
  localparam logic [6:0] PCT_N95   = 7'd95;
  localparam logic [6:0] PCT_N05   = 7'd5;
  localparam logic [7:0] OFFSET_LOW  = 8'd33;
  localparam logic [7:0] OFFSET_HIGH = 8'd64;
  localparam logic [63:0] WALK_CAP = 64'h0100_0000_0000_0000;

  function automatic logic [39:0] inc_sat40(logic [39:0] v);
    return (v == '1) ? v : v + 40'd1;
  endfunction

  function automatic logic [47:0] inc_sat48(logic [47:0] v);
    return (v == '1) ? v : v + 48'd1;
  endfunction

endpackage

@@ rtl/core/srs_item_if.sv @@
interface srs_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  base_char;
  logic [7:0]  quality_char;
  logic        end_of_read;
  logic [2:0]  table_select;
  logic [15:0] table_index;

  modport source (output valid, command, base_char, quality_char, end_of_read,
                  table_select, table_index, input ready);
  modport sink (input valid, command, base_char, quality_char, end_of_read,
                table_select, table_index, output ready);
endinterface

@@ rtl/core/srs_word_if.sv @@
interface srs_word_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_kind;
  logic [47:0] word_value;
  logic        last_word;

  modport source (output valid, word_kind, word_value, last_word, input ready);
  modport sink (input valid, word_kind, word_value, last_word, output ready);
endinterface

@@ rtl/core/sequencing_read_statistics_top.sv @@
// Read QC statistics over a stream of base requests. Base requests run back to back at one
// per cycle: the quality histogram is updated read-modify-write with forwarding of the last
// write. A base ending a non-empty read stalls requests for the totals, the GC-percent and
// mean-quality divisions on the shared radix-2 divider (9 quotient bits each) and the
// read-modify-write of the length, GC and mean-quality histograms. A finish request walks
// the length histogram one bin at a time (read, multiply, add and percentage steps, plus a
// step per Nxx percentage that bin settles), then sends 14 words one per cycle as they are
// taken. A table read sends one word, marked last. After reset and after each clear request
// the length, GC, quality and mean-quality memories are swept to zero, taking no request meanwhile.
module sequencing_read_statistics_top #(
  parameter int LENGTH_BINS = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  srs_item_if.sink   item,
  srs_word_if.source word
);

  localparam int LW = $clog2(LENGTH_BINS);
  localparam int RW = 40 + LW;

  srs_pkg::state_t state, state_next;

  // memories
  logic [39:0] len_mem  [LENGTH_BINS];
  logic [39:0] gc_mem   [srs_pkg::GC_BINS];
  logic [47:0] q_mem    [srs_pkg::QUAL_BINS];
  logic [39:0] mq_mem   [srs_pkg::QUAL_BINS];
  logic [31:0] nxx_mem  [srs_pkg::NXX_BINS];

  logic [LW-1:0] len_raddr, len_waddr;
  logic [6:0]    gc_raddr, gc_waddr, nxx_raddr, nxx_waddr;
  logic [7:0]    q_raddr, q_waddr, mq_raddr, mq_waddr;
  logic          len_we, gc_we, q_we, mq_we, nxx_we;
  logic [39:0]   len_wdata, gc_wdata, mq_wdata;
  logic [47:0]   q_wdata;
  logic [31:0]   nxx_wdata;
  logic [39:0]   len_rdata, gc_rdata, mq_rdata;
  logic [47:0]   q_rdata;
  logic [31:0]   nxx_rdata;

  // statistics
  logic [7:0]  offset_override;
  logic [39:0] total_reads;
  logic [47:0] total_bases;
  logic [31:0] longest;
  logic [47:0] cnt_a, cnt_c, cnt_g, cnt_t;
  logic [31:0] cur_len, cur_gc;
  logic [39:0] cur_sum;
  logic        overflow;
  logic        qlow_seen;

  // read close
  logic          close_pending;
  logic [31:0]   close_len, close_gc;
  logic [39:0]   close_sum;
  logic [LW-1:0] len_bin;
  logic [6:0]    gc_q;
  logic [7:0]    mq_q;
  logic [41:0]   div_rem;
  logic [32:0]   div_den;
  logic [8:0]    div_quo;
  logic [3:0]    div_step;
  logic          div_phase;

  // base forwarding
  logic [7:0]  q_addr;
  logic        q_do;
  logic        fwd_valid;
  logic [7:0]  fwd_addr;
  logic [47:0] fwd_val;

  // walk
  logic [LW-1:0] walk_len;
  logic [RW-1:0] reads_sum;
  logic [56:0]   bases_sum;
  logic [RW-1:0] walk_prod;
  logic          have_median;
  logic [LW-1:0] median;
  logic [6:0]    pct;
  logic [6:0]    nxx_fill;
  logic [LW-1:0] n50, n95, n05;

  logic [LW-1:0] clr_cnt;
  logic [3:0]    rep_idx;
  logic [2:0]    tab_sel;
  logic [15:0]   tab_idx;
  logic          tab_ok;

  // output register
  logic        out_valid;
  logic [3:0]  out_kind;
  logic [47:0] out_value;
  logic        out_last;
  logic        out_load;
  logic [3:0]  load_kind;
  logic [47:0] load_value;
  logic        load_last;
  logic        out_free;

  logic        accept;
  srs_pkg::cmd_t cmd;
  logic        take;
  logic        is_a, is_c, is_g, is_t;
  logic [31:0] len_new, gc_new;
  logic [39:0] sum_new;
  logic        tab_ok_in;
  logic [47:0] q_cur;
  logic [41:0] div_trial;
  logic        div_ge;
  logic [41:0] div_rem_n;
  logic [8:0]  div_quo_n;
  logic [63:0] walk_sum;
  logic        pct_hit;
  logic [48:0] tb_sum;
  logic [49:0] letters;
  logic        len_over;

  assign cmd    = srs_pkg::cmd_t'(item.command);
  assign accept = item.valid && item.ready;
  assign out_free = !out_valid || word.ready;

  assign take = (cur_len != '1);
  assign is_a = (item.base_char == "A") || (item.base_char == "a");
  assign is_c = (item.base_char == "C") || (item.base_char == "c");
  assign is_g = (item.base_char == "G") || (item.base_char == "g");
  assign is_t = (item.base_char == "T") || (item.base_char == "t") ||
                (item.base_char == "U") || (item.base_char == "u");
  assign len_new = take ? cur_len + 32'd1 : cur_len;
  assign gc_new  = (take && (is_c || is_g)) ? cur_gc + 32'd1 : cur_gc;
  assign sum_new = take ? cur_sum + 40'(item.quality_char) : cur_sum;

  always_comb begin
    case (item.table_select)
      srs_pkg::SEL_LENGTH: tab_ok_in = 32'(item.table_index) < 32'(LENGTH_BINS);
      srs_pkg::SEL_GC:     tab_ok_in = item.table_index < 16'(srs_pkg::GC_BINS);
      srs_pkg::SEL_QUAL:   tab_ok_in = item.table_index < 16'(srs_pkg::QUAL_BINS);
      srs_pkg::SEL_MEANQ:  tab_ok_in = item.table_index < 16'(srs_pkg::QUAL_BINS);
      srs_pkg::SEL_NXX:    tab_ok_in = (item.table_index != 16'd0) &&
                                       (item.table_index < 16'(nxx_fill));
      default:             tab_ok_in = 1'b0;
    endcase
  end

  assign q_cur = (fwd_valid && fwd_addr == q_addr) ? fwd_val : q_rdata;

  assign div_trial = 42'(div_den) << div_step;
  assign div_ge    = div_rem >= div_trial;
  assign div_rem_n = div_ge ? div_rem - div_trial : div_rem;
  assign div_quo_n = div_quo | (div_ge ? (9'd1 << div_step) : 9'd0);

  assign walk_sum = 64'(bases_sum) + 64'(walk_prod);
  assign pct_hit  = (pct <= srs_pkg::PCT_MAX) &&
                    (64'(bases_sum) * 64'd100 > 64'(total_bases) * 64'(pct));
  assign tb_sum   = 49'(total_bases) + 49'(close_len);
  assign letters  = 50'(cnt_a) + 50'(cnt_c) + 50'(cnt_g) + 50'(cnt_t);
  assign len_over = close_len > 32'(LENGTH_BINS - 1);

  // memories
  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rdata <= len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (gc_we) gc_mem[gc_waddr] <= gc_wdata;
    gc_rdata <= gc_mem[gc_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (mq_we) mq_mem[mq_waddr] <= mq_wdata;
    mq_rdata <= mq_mem[mq_raddr];
  end

  always_ff @(posedge clk) begin
    if (nxx_we) nxx_mem[nxx_waddr] <= nxx_wdata;
    nxx_rdata <= nxx_mem[nxx_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    out_load   = 1'b0;
    load_kind  = rep_idx;
    load_value = '0;
    load_last  = 1'b0;
    len_we = 1'b0; gc_we = 1'b0; q_we = 1'b0; mq_we = 1'b0; nxx_we = 1'b0;
    len_waddr = clr_cnt;
    gc_waddr  = clr_cnt[6:0];
    q_waddr   = clr_cnt[7:0];
    mq_waddr  = clr_cnt[7:0];
    nxx_waddr = pct;
    len_wdata = '0;
    gc_wdata  = '0;
    q_wdata   = '0;
    mq_wdata  = '0;
    nxx_wdata = 32'(walk_len);
    len_raddr = walk_len;
    gc_raddr  = gc_q;
    q_raddr   = item.quality_char;
    mq_raddr  = mq_q;
    nxx_raddr = tab_idx[6:0];

    case (state)
      srs_pkg::ST_CLEAR: begin
        len_we = 1'b1;
        gc_we  = clr_cnt < LW'(srs_pkg::GC_BINS);
        q_we   = clr_cnt < LW'(srs_pkg::QUAL_BINS);
        mq_we  = clr_cnt < LW'(srs_pkg::QUAL_BINS);
        if (clr_cnt == LW'(LENGTH_BINS - 1)) state_next = srs_pkg::ST_IDLE;
      end
      srs_pkg::ST_IDLE, srs_pkg::ST_QWRITE: begin
        if (state == srs_pkg::ST_QWRITE) begin
          q_we    = q_do;
          q_waddr = q_addr;
          q_wdata = srs_pkg::inc_sat48(q_cur);
        end
        if (state == srs_pkg::ST_QWRITE && close_pending) begin
          state_next = srs_pkg::ST_DIV;
        end else begin
          item.ready = 1'b1;
          state_next = srs_pkg::ST_IDLE;
          if (item.valid) begin
            case (cmd)
              srs_pkg::CMD_BASE:   state_next = srs_pkg::ST_QWRITE;
              srs_pkg::CMD_FINISH: state_next = srs_pkg::ST_WREAD;
              srs_pkg::CMD_READ:   state_next = srs_pkg::ST_TREAD;
              srs_pkg::CMD_CLEAR:  state_next = srs_pkg::ST_CLEAR;
              default:             state_next = srs_pkg::ST_IDLE;
            endcase
          end
        end
      end
      srs_pkg::ST_DIV: begin
        if (div_step == 4'd0 && div_phase) state_next = srs_pkg::ST_HREAD;
      end
      srs_pkg::ST_HREAD: begin
        len_raddr  = len_bin;
        state_next = srs_pkg::ST_HWRITE;
      end
      srs_pkg::ST_HWRITE: begin
        len_we    = 1'b1;
        len_waddr = len_bin;
        len_wdata = srs_pkg::inc_sat40(len_rdata);
        gc_we     = 1'b1;
        gc_waddr  = gc_q;
        gc_wdata  = srs_pkg::inc_sat40(gc_rdata);
        mq_we     = 1'b1;
        mq_waddr  = mq_q;
        mq_wdata  = srs_pkg::inc_sat40(mq_rdata);
        state_next = srs_pkg::ST_IDLE;
      end
      srs_pkg::ST_WREAD: state_next = srs_pkg::ST_WMUL;
      srs_pkg::ST_WMUL:  state_next = srs_pkg::ST_WADD;
      srs_pkg::ST_WADD:  state_next = srs_pkg::ST_WPCT;
      srs_pkg::ST_WPCT: begin
        if (pct_hit) begin
          nxx_we = 1'b1;
        end else if (walk_len == LW'(1)) begin
          state_next = srs_pkg::ST_REPORT;
        end else begin
          state_next = srs_pkg::ST_WREAD;
        end
      end
      srs_pkg::ST_REPORT: begin
        case (rep_idx)
          srs_pkg::KIND_READS:   load_value = 48'(total_reads);
          srs_pkg::KIND_BASES:   load_value = total_bases;
          srs_pkg::KIND_LONGEST: load_value = 48'(longest);
          srs_pkg::KIND_MEDIAN:  load_value = 48'(median);
          srs_pkg::KIND_N50:     load_value = 48'(n50);
          srs_pkg::KIND_N95:     load_value = 48'(n95);
          srs_pkg::KIND_N05:     load_value = 48'(n05);
          srs_pkg::KIND_A:       load_value = cnt_a;
          srs_pkg::KIND_C:       load_value = cnt_c;
          srs_pkg::KIND_G:       load_value = cnt_g;
          srs_pkg::KIND_TU:      load_value = cnt_t;
          srs_pkg::KIND_OFFSET: begin
            if (offset_override != 8'd0) load_value = 48'(offset_override);
            else if (qlow_seen)          load_value = 48'(srs_pkg::OFFSET_LOW);
            else                         load_value = 48'(srs_pkg::OFFSET_HIGH);
          end
          srs_pkg::KIND_OTHER:   load_value = 48'(letters != 50'(total_bases));
          srs_pkg::KIND_OVERFLOW: begin
            load_value = 48'(overflow);
            load_last  = 1'b1;
          end
          default:               load_value = '0;
        endcase
        if (out_free) begin
          out_load = 1'b1;
          if (rep_idx == srs_pkg::KIND_OVERFLOW) state_next = srs_pkg::ST_IDLE;
        end
      end
      srs_pkg::ST_TREAD, srs_pkg::ST_TOUT: begin
        len_raddr = LW'(tab_idx);
        gc_raddr  = tab_idx[6:0];
        q_raddr   = tab_idx[7:0];
        mq_raddr  = tab_idx[7:0];
        load_kind = srs_pkg::KIND_TABLE;
        load_last = 1'b1;
        if (tab_ok) begin
          case (tab_sel)
            srs_pkg::SEL_LENGTH: load_value = 48'(len_rdata);
            srs_pkg::SEL_GC:     load_value = 48'(gc_rdata);
            srs_pkg::SEL_QUAL:   load_value = q_rdata;
            srs_pkg::SEL_MEANQ:  load_value = 48'(mq_rdata);
            srs_pkg::SEL_NXX:    load_value = 48'(nxx_rdata);
            default:             load_value = '0;
          endcase
        end
        if (state == srs_pkg::ST_TREAD) begin
          state_next = srs_pkg::ST_TOUT;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = srs_pkg::ST_IDLE;
        end
      end
      default: state_next = srs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_override <= 8'd0;
    end else if (cfg_write) begin
      offset_override <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= q_we && state == srs_pkg::ST_QWRITE;
    end
    fwd_addr <= q_waddr;
    fwd_val  <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && cmd == srs_pkg::CMD_CLEAR)) begin
      total_reads   <= '0;
      total_bases   <= '0;
      longest       <= '0;
      cnt_a         <= '0;
      cnt_c         <= '0;
      cnt_g         <= '0;
      cnt_t         <= '0;
      cur_len       <= '0;
      cur_gc        <= '0;
      cur_sum       <= '0;
      overflow      <= 1'b0;
      qlow_seen     <= 1'b0;
      close_pending <= 1'b0;
      q_do          <= 1'b0;
      nxx_fill      <= 7'd1;
      median        <= '0;
      n50           <= '0;
      n95           <= '0;
      n05           <= '0;
      clr_cnt       <= '0;
      rep_idx       <= srs_pkg::KIND_READS;
    end else begin
      if (state == srs_pkg::ST_CLEAR) clr_cnt <= clr_cnt + LW'(1);

      if (accept) begin
        case (cmd)
          srs_pkg::CMD_BASE: begin
            if (take) begin
              if (is_a) cnt_a <= srs_pkg::inc_sat48(cnt_a);
              if (is_c) cnt_c <= srs_pkg::inc_sat48(cnt_c);
              if (is_g) cnt_g <= srs_pkg::inc_sat48(cnt_g);
              if (is_t) cnt_t <= srs_pkg::inc_sat48(cnt_t);
              if (item.quality_char >= srs_pkg::OFFSET_LOW &&
                  item.quality_char < srs_pkg::OFFSET_HIGH) qlow_seen <= 1'b1;
            end
            q_addr <= item.quality_char;
            q_do   <= take;
            if (item.end_of_read) begin
              close_len     <= len_new;
              close_gc      <= gc_new;
              close_sum     <= sum_new;
              close_pending <= len_new != 32'd0;
              cur_len       <= '0;
              cur_gc        <= '0;
              cur_sum       <= '0;
            end else begin
              cur_len <= len_new;
              cur_gc  <= gc_new;
              cur_sum <= sum_new;
            end
          end
          srs_pkg::CMD_FINISH: begin
            walk_len    <= LW'(LENGTH_BINS - 1);
            reads_sum   <= '0;
            bases_sum   <= '0;
            have_median <= 1'b0;
            median      <= '0;
            pct         <= 7'd1;
            nxx_fill    <= 7'd1;
            n50         <= '0;
            n95         <= '0;
            n05         <= '0;
            rep_idx     <= srs_pkg::KIND_READS;
          end
          srs_pkg::CMD_READ: begin
            tab_sel <= item.table_select;
            tab_idx <= item.table_index;
            tab_ok  <= tab_ok_in;
          end
          default: begin
          end
        endcase
      end

      case (state)
        srs_pkg::ST_QWRITE: begin
          if (close_pending) begin
            close_pending <= 1'b0;
            if (close_len > longest) longest <= close_len;
            total_reads <= srs_pkg::inc_sat40(total_reads);
            total_bases <= tb_sum[48] ? '1 : tb_sum[47:0];
            len_bin     <= len_over ? LW'(LENGTH_BINS - 1) : close_len[LW-1:0];
            if (len_over) overflow <= 1'b1;
            div_rem   <= 42'(close_gc) * 42'd200 + 42'(close_len);
            div_den   <= {close_len, 1'b0};
            div_quo   <= '0;
            div_step  <= 4'd8;
            div_phase <= 1'b0;
          end
        end
        srs_pkg::ST_DIV: begin
          if (div_step == 4'd0) begin
            if (!div_phase) begin
              gc_q      <= (div_quo_n > 9'(srs_pkg::GC_MAX)) ? srs_pkg::GC_MAX : div_quo_n[6:0];
              div_rem   <= 42'({close_sum, 1'b0}) + 42'(close_len);
              div_quo   <= '0;
              div_step  <= 4'd8;
              div_phase <= 1'b1;
            end else begin
              mq_q <= div_quo_n[8] ? 8'hFF : div_quo_n[7:0];
            end
          end else begin
            div_rem  <= div_rem_n;
            div_quo  <= div_quo_n;
            div_step <= div_step - 4'd1;
          end
        end
        srs_pkg::ST_WMUL: begin
          reads_sum <= reads_sum + RW'(len_rdata);
          walk_prod <= RW'(len_rdata) * RW'(walk_len);
        end
        srs_pkg::ST_WADD: begin
          bases_sum <= (walk_sum > srs_pkg::WALK_CAP) ? srs_pkg::WALK_CAP[56:0]
                                                      : walk_sum[56:0];
          if (!have_median && {reads_sum, 1'b0} > (RW + 1)'(total_reads)) begin
            have_median <= 1'b1;
            median      <= walk_len;
          end
        end
        srs_pkg::ST_WPCT: begin
          if (pct_hit) begin
            pct      <= pct + 7'd1;
            nxx_fill <= pct + 7'd1;
            if (pct == srs_pkg::PCT_N50) n50 <= walk_len;
            if (pct == srs_pkg::PCT_N95) n95 <= walk_len;
            if (pct == srs_pkg::PCT_N05) n05 <= walk_len;
          end else if (walk_len != LW'(1)) begin
            walk_len <= walk_len - LW'(1);
          end
        end
        srs_pkg::ST_REPORT: begin
          if (out_free) rep_idx <= rep_idx + 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (word.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_kind  <= load_kind;
      out_value <= load_value;
      out_last  <= load_last;
    end
  end

  assign word.valid      = out_valid;
  assign word.word_kind  = out_kind;
  assign word.word_value = out_value;
  assign word.last_word  = out_last;

endmodule

@@ tb/tb_sequencing_read_statistics_top.sv @@
`timescale 1ns / 1ps

module tb_sequencing_read_statistics_top;

  localparam int LB = 1024;
  localparam int CYCLE_LIMIT = 4000000;
  localparam longint unsigned MAX32 = 64'hFFFF_FFFF;
  localparam longint unsigned MAX40 = 64'hFF_FFFF_FFFF;
  localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    srs_pkg::cmd_t cmd;
    logic [7:0]  base_char;
    logic [7:0]  quality_char;
    logic        end_of_read;
    logic [2:0]  table_select;
    logic [15:0] table_index;
  } request_t;

  typedef struct {
    logic [3:0]  kind;
    logic [47:0] value;
    logic        last;
  } stat_word_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [7:0] cfg_data;

  srs_item_if item ();
  srs_word_if word ();

  sequencing_read_statistics_top #(.LENGTH_BINS(LB)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .item(item),
    .word(word)
  );

  request_t   pending_requests[$];
  stat_word_t expected_words[$];
  int errors;
  int send_idle;
  int recv_idle;
  logic hold_go;
  logic hold_off;
  int cycles;

  // statistics mirror
  longint unsigned len_hist[LB];
  longint unsigned gc_hist[srs_pkg::GC_BINS];
  longint unsigned qual_hist[srs_pkg::QUAL_BINS];
  longint unsigned meanq_hist[srs_pkg::QUAL_BINS];
  longint unsigned nxx_len[srs_pkg::NXX_BINS];
  longint unsigned n_reads, n_bases, longest;
  longint unsigned letters[4];
  longint unsigned cur_len, cur_gc, cur_qsum;
  logic overflow_seen;
  logic [7:0] offset_override;

  function automatic longint unsigned sat_add(longint unsigned v, longint unsigned a,
                                              longint unsigned max);
    if (v >= max || a > max - v) return max;
    return v + a;
  endfunction

  function automatic void clear_stats();
    foreach (len_hist[i]) len_hist[i] = 0;
    foreach (gc_hist[i]) gc_hist[i] = 0;
    foreach (qual_hist[i]) qual_hist[i] = 0;
    foreach (meanq_hist[i]) meanq_hist[i] = 0;
    foreach (nxx_len[i]) nxx_len[i] = 0;
    foreach (letters[i]) letters[i] = 0;
    n_reads = 0;
    n_bases = 0;
    longest = 0;
    cur_len = 0;
    cur_gc = 0;
    cur_qsum = 0;
    overflow_seen = 1'b0;
  endfunction

  function automatic void close_read();
    longint unsigned bin, gc, mq;
    if (cur_len != 0) begin
      if (cur_len > longest) longest = cur_len;
      n_reads = sat_add(n_reads, 1, MAX40);
      n_bases = sat_add(n_bases, cur_len, MAX48);
      bin = cur_len;
      if (bin > LB - 1) begin
        bin = LB - 1;
        overflow_seen = 1'b1;
      end
      len_hist[bin] = sat_add(len_hist[bin], 1, MAX40);
      gc = (200 * cur_gc + cur_len) / (2 * cur_len);
      if (gc > 100) gc = 100;
      gc_hist[gc] = sat_add(gc_hist[gc], 1, MAX40);
      mq = (2 * cur_qsum + cur_len) / (2 * cur_len);
      if (mq > 255) mq = 255;
      meanq_hist[mq] = sat_add(meanq_hist[mq], 1, MAX40);
    end
    cur_len = 0;
    cur_gc = 0;
    cur_qsum = 0;
  endfunction

  function automatic void take_base(logic [7:0] ch, logic [7:0] q);
    int li;
    if (cur_len >= MAX32) return;
    li = -1;
    case (ch)
      "A", "a": li = 0;
      "C", "c": li = 1;
      "G", "g": li = 2;
      "T", "t", "U", "u": li = 3;
      default: li = -1;
    endcase
    if (li >= 0) letters[li] = sat_add(letters[li], 1, MAX48);
    if (li == 1 || li == 2) cur_gc++;
    qual_hist[q] = sat_add(qual_hist[q], 1, MAX48);
    cur_qsum += q;
    cur_len++;
  endfunction

  function automatic longint unsigned walk_lengths();
    longint unsigned rsum, bsum, median, pct, c;
    logic have;
    rsum = 0;
    bsum = 0;
    median = 0;
    pct = 1;
    have = 1'b0;
    foreach (nxx_len[i]) nxx_len[i] = 0;
    for (int l = LB - 1; l > 0; l--) begin
      c = len_hist[l];
      rsum += c;
      bsum += c * l;
      if (bsum > srs_pkg::WALK_CAP) bsum = srs_pkg::WALK_CAP;
      if (!have && rsum * 2 > n_reads) begin
        median = l;
        have = 1'b1;
      end
      while (pct <= 100 && bsum * 100 > n_bases * pct) begin
        nxx_len[pct] = l;
        pct++;
      end
    end
    return median;
  endfunction

  function automatic void push_word(logic [3:0] k, longint unsigned v, logic last);
    stat_word_t w;
    w.kind = k;
    w.value = v[47:0];
    w.last = last;
    expected_words.push_back(w);
  endfunction

  function automatic longint unsigned table_entry(logic [2:0] sel, logic [15:0] idx);
    case (sel)
      srs_pkg::SEL_LENGTH: return idx < LB ? len_hist[idx] : 0;
      srs_pkg::SEL_GC:     return idx < srs_pkg::GC_BINS ? gc_hist[idx] : 0;
      srs_pkg::SEL_QUAL:   return idx < srs_pkg::QUAL_BINS ? qual_hist[idx] : 0;
      srs_pkg::SEL_MEANQ:  return idx < srs_pkg::QUAL_BINS ? meanq_hist[idx] : 0;
      srs_pkg::SEL_NXX:    return idx < srs_pkg::NXX_BINS ? nxx_len[idx] : 0;
      default:             return 0;
    endcase
  endfunction

  function automatic void stats_accept(request_t r);
    longint unsigned median, offset, lsum;
    case (r.cmd)
      srs_pkg::CMD_BASE: begin
        take_base(r.base_char, r.quality_char);
        if (r.end_of_read) close_read();
      end
      srs_pkg::CMD_FINISH: begin
        median = walk_lengths();
        offset = offset_override;
        if (offset == 0) begin
          offset = srs_pkg::OFFSET_HIGH;
          for (int i = 33; i < 64; i++) if (qual_hist[i] > 0) offset = srs_pkg::OFFSET_LOW;
        end
        lsum = letters[0] + letters[1] + letters[2] + letters[3];
        push_word(srs_pkg::KIND_READS, n_reads, 1'b0);
        push_word(srs_pkg::KIND_BASES, n_bases, 1'b0);
        push_word(srs_pkg::KIND_LONGEST, longest, 1'b0);
        push_word(srs_pkg::KIND_MEDIAN, median, 1'b0);
        push_word(srs_pkg::KIND_N50, nxx_len[srs_pkg::PCT_N50], 1'b0);
        push_word(srs_pkg::KIND_N95, nxx_len[srs_pkg::PCT_N95], 1'b0);
        push_word(srs_pkg::KIND_N05, nxx_len[srs_pkg::PCT_N05], 1'b0);
        push_word(srs_pkg::KIND_A, letters[0], 1'b0);
        push_word(srs_pkg::KIND_C, letters[1], 1'b0);
        push_word(srs_pkg::KIND_G, letters[2], 1'b0);
        push_word(srs_pkg::KIND_TU, letters[3], 1'b0);
        push_word(srs_pkg::KIND_OFFSET, offset, 1'b0);
        push_word(srs_pkg::KIND_OTHER, (lsum != n_bases) ? 64'd1 : 64'd0, 1'b0);
        push_word(srs_pkg::KIND_OVERFLOW, 64'(overflow_seen), 1'b1);
      end
      srs_pkg::CMD_READ:
        push_word(srs_pkg::KIND_TABLE, table_entry(r.table_select, r.table_index), 1'b1);
      default: clear_stats();
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        stats_accept('{srs_pkg::cmd_t'(item.command), item.base_char, item.quality_char,
                       item.end_of_read, item.table_select, item.table_index});
      end
      if (!item.valid || item.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
          request_t r;
          r = pending_requests.pop_front();
          item.valid <= 1'b1;
          item.command <= r.cmd;
          item.base_char <= r.base_char;
          item.quality_char <= r.quality_char;
          item.end_of_read <= r.end_of_read;
          item.table_select <= r.table_select;
          item.table_index <= r.table_index;
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // word monitor
  always @(posedge clk) begin
    if (rst) begin
      word.ready <= 1'b0;
    end else begin
      if (word.valid && word.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d value %0h",
                                    word.word_kind, word.word_value));
        end else begin
          stat_word_t w;
          w = expected_words.pop_front();
          if (word.word_kind !== w.kind)
            report_mismatch($sformatf("kind %0d, want %0d", word.word_kind, w.kind));
          if (word.word_value !== w.value)
            report_mismatch($sformatf("kind %0d value %0h, want %0h", w.kind,
                                      word.word_value, w.value));
          if (word.last_word !== w.last)
            report_mismatch($sformatf("kind %0d last %0b, want %0b", w.kind,
                                      word.last_word, w.last));
        end
      end
      word.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // long receiver hold-off
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sequencing_read_statistics_top NOT OK");
      $finish;
    end
  end

  function automatic request_t mk(srs_pkg::cmd_t c, int b, int q, int e, int s, int x);
    request_t r;
    r.cmd = c;
    r.base_char = 8'(b);
    r.quality_char = 8'(q);
    r.end_of_read = e[0];
    r.table_select = 3'(s);
    r.table_index = 16'(x);
    return r;
  endfunction

  function automatic request_t noise(srs_pkg::cmd_t c);
    return mk(c, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic logic [7:0] pick_letter();
    string pool;
    pool = "ACGTUacgtuNn-*";
    if ($urandom_range(9) == 0) return 8'($urandom);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic void queue_read(int n, int qlo, int qhi);
    for (int i = 0; i < n; i++) begin
      request_t r;
      r = noise(srs_pkg::CMD_BASE);
      r.base_char = pick_letter();
      r.quality_char = 8'($urandom_range(qhi, qlo));
      r.end_of_read = (i == n - 1);
      pending_requests.push_back(r);
    end
  endfunction

  function automatic request_t table_read();
    request_t r;
    r = noise(srs_pkg::CMD_READ);
    if ($urandom_range(3) != 0) begin
      r.table_select = 3'($urandom_range(4));
      r.table_index = 16'($urandom_range(r.table_select == srs_pkg::SEL_LENGTH ? LB - 1 : 100));
    end
    return r;
  endfunction

  task automatic drain();
    while (pending_requests.size() != 0 || item.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (LB + 100) @(posedge clk);
  endtask

  task automatic write_offset(logic [7:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    offset_override = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int sent;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        int len;
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        if ($urandom_range(1)) queue_read(len, 33, 73);
        else if ($urandom_range(1)) queue_read(len, 64, 104);
        else queue_read(len, 0, 255);
        sent += len;
      end else begin
        if (r < 85) pending_requests.push_back(table_read());
        else if (r < 93) pending_requests.push_back(noise(srs_pkg::CMD_FINISH));
        else if (r < 95) pending_requests.push_back(noise(srs_pkg::CMD_CLEAR));
        else pending_requests.push_back(noise(srs_pkg::CMD_BASE));
        sent++;
      end
    end
    pending_requests.push_back(noise(srs_pkg::CMD_FINISH));
  endtask

  initial begin
    string acgt;
    errors = 0;
    cycles = 0;
    hold_go = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    cfg_write = 1'b0;
    cfg_data = 8'd0;
    item.valid = 1'b0;
    item.command = srs_pkg::CMD_BASE;
    item.base_char = 8'd0;
    item.quality_char = 8'd0;
    item.end_of_read = 1'b0;
    item.table_select = 3'd0;
    item.table_index = 16'd0;
    word.ready = 1'b0;
    clear_stats();
    offset_override = 8'd0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_offset(8'd0);

    // directed: empty finish, letters of both cases, quality extremes, odd tables
    pending_requests.push_back(mk(srs_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_LENGTH, 0));
    acgt = "ACGTUacgtuN";
    for (int i = 0; i < acgt.len(); i++)
      pending_requests.push_back(mk(srs_pkg::CMD_BASE, int'(acgt[i]), (i == 0) ? 0 : 255,
                                    int'(i == acgt.len() - 1), 0, 0));
    pending_requests.push_back(mk(srs_pkg::CMD_BASE, "G", 63, 1, 0, 0));
    pending_requests.push_back(mk(srs_pkg::CMD_BASE, 8'hFF, 33, 0, 7, 16'hFFFF));
    pending_requests.push_back(mk(srs_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_NXX, 50));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_NXX, 101));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_GC, 100));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_QUAL, 255));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_MEANQ, 127));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, 5, 1));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_LENGTH, 16'hFFFF));
    pending_requests.push_back(mk(srs_pkg::CMD_BASE, "a", 10, 1, 0, 0));
    drain();

    write_offset(8'd255);
    pending_requests.push_back(mk(srs_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    drain();

    // last length bin and just past it
    write_offset(8'd33);
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_LENGTH, LB - 1));
    pending_requests.push_back(mk(srs_pkg::CMD_READ, 0, 0, 0, srs_pkg::SEL_LENGTH, LB));
    pending_requests.push_back(mk(srs_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    drain();

    write_offset(8'd64);
    pending_requests.push_back(mk(srs_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
    pending_requests.push_back(mk(srs_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    drain();

    write_offset(8'd0);
    queue_read(5, 64, 100);
    pending_requests.push_back(mk(srs_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    drain();

    send_idle = 16;
    recv_idle = 77;
    random_phase(35);
    drain();

    write_offset(8'd1);
    send_idle = 77;
    recv_idle = 16;
    random_phase(30);
    drain();

    write_offset(8'd0);
    send_idle = 0;
    recv_idle = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 6; i++) begin
      pending_requests.push_back(table_read());
      queue_read(4, 33, 90);
    end
    random_phase(25);
    drain();

    if (errors == 0) begin
      $display("tb_sequencing_read_statistics_top OK");
    end else begin
      $display("tb_sequencing_read_statistics_top NOT OK");
    end
    $finish;
  end

endmodule
